[rtl/iff_pkg.sv]
// Shared constants, command and status types, and a character helper for the integer field formatter.
`timescale 1ns / 1ps

package iff_pkg;

	// Field limits
	localparam int MAX_WIDTH    = 63;
	localparam int DIGIT_BUFFER = 32;
	localparam int RESULT_LIMIT = 63;
	localparam int LINE_LIMIT   = (MAX_WIDTH < RESULT_LIMIT) ? MAX_WIDTH : RESULT_LIMIT;

	// Datapath sizes
	localparam int BIN_W      = 32;
	localparam int DEC_DIGITS = 10;
	localparam int BCD_W      = 4 * DEC_DIGITS;
	localparam int ND_W       = $clog2(DEC_DIGITS + 1);
	localparam int LEN_W      = 7;
	localparam int CNT_W      = $clog2(LINE_LIMIT + 1);
	localparam int IT_W       = $clog2(BIN_W);

	// Conversion codes
	localparam logic [2:0] CMD_DEC    = 3'd0;
	localparam logic [2:0] CMD_UNS    = 3'd1;
	localparam logic [2:0] CMD_HEX    = 3'd2;
	localparam logic [2:0] CMD_HEX_UP = 3'd3;
	localparam logic [2:0] CMD_PTR    = 3'd4;
	localparam logic [2:0] CMD_FAR    = 3'd5;

	// ASCII characters
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_X       = 8'h78;

	// Length of the segment:offset field
	localparam int FAR_LEN = 13;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
		logic count;
		logic plan;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic decimal;
		logic conv_last;
		logic empty;
		logic last;
	} dp_status_t;

	// Map one digit value to its ASCII character
	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (nib < 4'd10) begin
			return CH_ZERO + {4'b0000, nib};
		end
		return base + {4'b0000, nib} - 8'd10;
	endfunction

endpackage

[rtl/iff_ctrl.sv]
// Sequencing state machine of the integer field formatter.
`timescale 1ns / 1ps

module iff_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output iff_pkg::dp_cmd_t   cmd,
	input  iff_pkg::dp_status_t st
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CONV  = 5'b00010,
		S_COUNT = 5'b00100,
		S_PLAN  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Hold off new items until the field is out
	assign busy = (state_q != S_IDLE);

	// Pick next state and issue datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				if (!st.decimal) begin
					state_d = S_COUNT;
				end else begin
					cmd.step = 1'b1;
					if (st.conv_last) begin
						state_d = S_COUNT;
					end
				end
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				state_d   = S_PLAN;
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (st.empty || st.last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/iff_datapath.sv]
// Digit conversion, field layout and character output of the integer field formatter.
`timescale 1ns / 1ps

module iff_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          command,
	input  logic                is_long,
	input  logic [31:0]         value,
	input  logic [5:0]          field_width,
	input  logic [5:0]          digit_precision,
	input  logic                zero_fill,
	input  iff_pkg::dp_cmd_t    cmd,
	output iff_pkg::dp_status_t st,
	output logic                strobe,
	output logic [7:0]          character,
	output logic                last_char
);

	localparam int BIN_W  = iff_pkg::BIN_W;
	localparam int BCD_W  = iff_pkg::BCD_W;
	localparam int DIGITS = iff_pkg::DEC_DIGITS;
	localparam int ND_W   = iff_pkg::ND_W;
	localparam int LEN_W  = iff_pkg::LEN_W;
	localparam int CNT_W  = iff_pkg::CNT_W;
	localparam int IT_W   = iff_pkg::IT_W;

	// Item registers
	logic [2:0]        cmd_q;
	logic              long_q;
	logic [31:0]       value_q;
	logic [5:0]        width_q;
	logic [5:0]        prec_q;
	logic              zfill_q;
	logic              neg_q;
	logic              zero_q;
	logic              decimal_q;

	// Conversion registers
	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [IT_W-1:0]   it_q;
	logic [ND_W-1:0]   nd_q;

	// Layout registers
	logic [LEN_W-1:0]  b1_q;
	logic [LEN_W-1:0]  b2_q;
	logic [LEN_W-1:0]  b3_q;
	logic [ND_W-1:0]   nde_q;
	logic [CNT_W-1:0]  out_len_q;
	logic              ptr_q;
	logic              far_q;
	logic [CNT_W-1:0]  k_q;

	// Output registers
	logic              strobe_q;
	logic [7:0]        char_q;
	logic              last_q;

	// Decode the incoming item
	logic              neg_in;
	logic              decimal_in;
	logic [BIN_W-1:0]  mag_in;
	logic [15:0]       mag16;

	assign mag16      = value[15:0];
	assign decimal_in = (command == iff_pkg::CMD_DEC) || (command == iff_pkg::CMD_UNS);
	assign neg_in     = (command == iff_pkg::CMD_DEC) && (is_long ? value[31] : value[15]);

	always_comb begin
		if (command == iff_pkg::CMD_PTR) begin
			mag_in = {16'h0000, mag16};
		end else if (is_long) begin
			mag_in = neg_in ? (~value + 32'd1) : value;
		end else begin
			mag_in = {16'h0000, neg_in ? (~mag16 + 16'd1) : mag16};
		end
	end

	// Add three to every BCD digit of five or more before the shift
	logic [BCD_W-1:0] adj;
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
			                                          : bcd_q[4*i +: 4];
		end
	end

	// Count significant digits, at least one
	logic [ND_W-1:0] nd_c;
	always_comb begin
		nd_c = ND_W'(1);
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				nd_c = ND_W'(i + 1);
			end
		end
	end

	// Lay out the field: spaces, sign or prefix, zeros, digits; P has a fixed segment:offset length
	logic              prec_given;
	logic              use_prec;
	logic              zp;
	logic [LEN_W-1:0]  prec_mag;
	logic [LEN_W-1:0]  pc;
	logic [LEN_W-1:0]  nd7;
	logic [LEN_W-1:0]  w7;
	logic [LEN_W-1:0]  md;
	logic [LEN_W-1:0]  lead;
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  pad;
	logic [LEN_W-1:0]  sgn;
	logic [LEN_W-1:0]  pre;
	logic [LEN_W-1:0]  pfx;
	logic [LEN_W-1:0]  zeros;
	logic [LEN_W-1:0]  nde;
	logic [LEN_W-1:0]  total;
	logic              ptr_c;
	logic              far_c;

	assign prec_given = !prec_q[5];
	assign prec_mag   = {2'b00, prec_q[4:0]};
	assign pc         = (prec_mag > LEN_W'(iff_pkg::DIGIT_BUFFER)) ?
	                    LEN_W'(iff_pkg::DIGIT_BUFFER) : prec_mag;
	assign nd7        = LEN_W'(nd_q);
	assign w7         = {1'b0, width_q};
	assign use_prec   = decimal_q && prec_given;
	assign sgn        = {{(LEN_W-1){1'b0}}, neg_q};

	always_comb begin
		zp    = 1'b0;
		md    = '0;
		lead  = '0;
		len   = '0;
		pad   = '0;
		pre   = '0;
		pfx   = '0;
		zeros = '0;
		nde   = '0;
		total = '0;
		ptr_c = 1'b0;
		far_c = 1'b0;
		case (cmd_q) inside
			iff_pkg::CMD_DEC, iff_pkg::CMD_UNS, iff_pkg::CMD_HEX, iff_pkg::CMD_HEX_UP: begin
				nde   = (use_prec && (pc == '0) && zero_q) ? '0 : nd7;
				lead  = (use_prec && (pc > nd7)) ? (pc - nd7) : '0;
				zp    = zfill_q && !use_prec;
				len   = sgn + lead + nde;
				pad   = (w7 > len) ? (w7 - len) : '0;
				pre   = zp ? '0 : pad;
				pfx   = sgn;
				zeros = lead + (zp ? pad : '0);
				total = pre + pfx + zeros + nde;
			end
			iff_pkg::CMD_PTR: begin
				md    = (prec_given && (prec_q != 6'd0)) ? pc : LEN_W'(4);
				lead  = (md > nd7) ? (md - nd7) : '0;
				len   = LEN_W'(2) + nd7 + lead;
				pad   = (w7 > len) ? (w7 - len) : '0;
				pre   = pad;
				pfx   = LEN_W'(2);
				zeros = lead;
				nde   = nd7;
				total = pre + pfx + zeros + nde;
				ptr_c = 1'b1;
			end
			iff_pkg::CMD_FAR: begin
				total = LEN_W'(iff_pkg::FAR_LEN);
				far_c = 1'b1;
			end
			default: begin
				total = '0;
			end
		endcase
	end

	// Pick the character at the current output position
	logic [LEN_W-1:0] k7;
	logic [LEN_W-1:0] j;
	logic [LEN_W-1:0] pos;
	logic [3:0]       digit_w [DIGITS];
	logic [7:0]       char_c;
	logic             upper;
	logic             last_c;
	logic             empty;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			digit_w[i] = bcd_q[4*i +: 4];
		end
	end

	assign k7    = {{(LEN_W-CNT_W){1'b0}}, k_q};
	assign j     = k7 - b3_q;
	assign pos   = LEN_W'(nde_q) - LEN_W'(1) - j;
	assign upper = (cmd_q == iff_pkg::CMD_HEX_UP) && long_q;

	always_comb begin
		char_c = iff_pkg::CH_SPACE;
		if (far_q) begin
			case (k_q)
				CNT_W'(0):  char_c = iff_pkg::CH_ZERO;
				CNT_W'(1):  char_c = iff_pkg::CH_X;
				CNT_W'(2):  char_c = iff_pkg::hex_char(value_q[31:28], 1'b0);
				CNT_W'(3):  char_c = iff_pkg::hex_char(value_q[27:24], 1'b0);
				CNT_W'(4):  char_c = iff_pkg::hex_char(value_q[23:20], 1'b0);
				CNT_W'(5):  char_c = iff_pkg::hex_char(value_q[19:16], 1'b0);
				CNT_W'(6):  char_c = iff_pkg::CH_COLON;
				CNT_W'(7):  char_c = iff_pkg::CH_ZERO;
				CNT_W'(8):  char_c = iff_pkg::CH_X;
				CNT_W'(9):  char_c = iff_pkg::hex_char(value_q[15:12], 1'b0);
				CNT_W'(10): char_c = iff_pkg::hex_char(value_q[11:8], 1'b0);
				CNT_W'(11): char_c = iff_pkg::hex_char(value_q[7:4], 1'b0);
				CNT_W'(12): char_c = iff_pkg::hex_char(value_q[3:0], 1'b0);
				default:    char_c = iff_pkg::CH_SPACE;
			endcase
		end else if (k7 < b1_q) begin
			char_c = iff_pkg::CH_SPACE;
		end else if (k7 < b2_q) begin
			if (ptr_q) begin
				char_c = (k7 == b1_q) ? iff_pkg::CH_ZERO : iff_pkg::CH_X;
			end else begin
				char_c = iff_pkg::CH_MINUS;
			end
		end else if (k7 < b3_q) begin
			char_c = iff_pkg::CH_ZERO;
		end else begin
			char_c = iff_pkg::hex_char(digit_w[pos[ND_W-1:0]], upper);
		end
	end

	assign last_c = ({1'b0, k_q} + (CNT_W+1)'(1)) == {1'b0, out_len_q};
	assign empty  = (out_len_q == '0);

	// Status to the controller
	assign st.decimal   = decimal_q;
	assign st.conv_last = (it_q == IT_W'(BIN_W - 1));
	assign st.empty     = empty;
	assign st.last      = last_c;

	// Load the item, shift the conversion, count digits, hold the layout, register each character
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= command;
			long_q    <= is_long;
			value_q   <= value;
			width_q   <= field_width;
			prec_q    <= digit_precision;
			zfill_q   <= zero_fill;
			neg_q     <= neg_in;
			zero_q    <= (mag_in == '0);
			decimal_q <= decimal_in;
			bin_q     <= mag_in;
			bcd_q     <= decimal_in ? '0 : {{(BCD_W-BIN_W){1'b0}}, mag_in};
			it_q      <= '0;
		end
		if (cmd.step) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			it_q  <= it_q + IT_W'(1);
		end
		if (cmd.count) begin
			nd_q <= nd_c;
		end
		if (cmd.plan) begin
			b1_q      <= pre;
			b2_q      <= pre + pfx;
			b3_q      <= pre + pfx + zeros;
			nde_q     <= nde[ND_W-1:0];
			out_len_q <= (total > LEN_W'(iff_pkg::LINE_LIMIT)) ?
			             CNT_W'(iff_pkg::LINE_LIMIT) : total[CNT_W-1:0];
			ptr_q     <= ptr_c;
			far_q     <= far_c;
			k_q       <= '0;
		end
		if (cmd.emit) begin
			char_q <= char_c;
			last_q <= last_c;
			k_q    <= k_q + CNT_W'(1);
		end
	end

	// Drive the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit && !empty;
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last_char = last_q;

endmodule

[rtl/integer_field_formatter.sv]
// Top level of the integer field formatter: controller and datapath.
`timescale 1ns / 1ps

// Formats one integer conversion (d, u, x, X, p, P) into its ASCII characters, one
// character per cycle on character/last_char, each marked by strobe for exactly one
// cycle; the receiver cannot stall, so it must take every strobed character. An item
// is taken when start is high and busy is low. A decimal item first sends its
// magnitude through a bit-serial binary-to-BCD shift, one bit per cycle; every item
// then counts its digits, plans the layout and emits its N characters (at most 63).
// The final character of each field carries last_char; fields that produce no
// characters give no strobe at all.

module integer_field_formatter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        command,
	input  logic              is_long,
	input  logic [31:0]       value,
	input  logic [5:0]        field_width,
	input  logic signed [5:0] digit_precision,
	input  logic              zero_fill,
	output logic              strobe,
	output logic [7:0]        character,
	output logic              last_char
);

	iff_pkg::dp_cmd_t    cmd;
	iff_pkg::dp_status_t st;

	// Sequence the item
	iff_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.st     (st)
	);

	// Convert and emit the field
	iff_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.command         (command),
		.is_long         (is_long),
		.value           (value),
		.field_width     (field_width),
		.digit_precision (digit_precision),
		.zero_fill       (zero_fill),
		.cmd             (cmd),
		.st              (st),
		.strobe          (strobe),
		.character       (character),
		.last_char       (last_char)
	);

endmodule
